// ----- src/salq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salq_pkg
// Shared types, constants and helpers for the suffix array / LCP query core.
// ----------------------------------------------------------------------------
package salq_pkg;

    // Sizing
    localparam int MAX_LENGTH   = 1024;
    localparam int TABLE_LEVELS = 11;
    localparam int ALPHABET_MAX = 127;

    // Field widths (fixed by the transaction format)
    localparam int SYM_W = 7;
    localparam int POS_W = 10;
    localparam int STA_W = 2;
    localparam int PLN_W = 11;

    // Derived storage geometry
    localparam int IDX_W     = $clog2(MAX_LENGTH);
    localparam int BKT_DEPTH = (MAX_LENGTH + 1 > ALPHABET_MAX + 2) ? MAX_LENGTH + 1
                                                                   : ALPHABET_MAX + 2;
    localparam int BKT_AW    = $clog2(BKT_DEPTH);
    localparam int VAL_W     = $clog2(BKT_DEPTH + 1);
    localparam int MT_DEPTH  = TABLE_LEVELS * MAX_LENGTH;
    localparam int MT_AW     = $clog2(MT_DEPTH);
    localparam int LV_W      = $clog2(TABLE_LEVELS + 1);
    localparam int TOP0      = (ALPHABET_MAX + 1 < BKT_DEPTH - 1) ? ALPHABET_MAX + 1
                                                                  : BKT_DEPTH - 1;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Status codes
    localparam logic [STA_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STA_W-1:0] ST_ANSWER = 2'd1;
    localparam logic [STA_W-1:0] ST_RANGE  = 2'd2;

    typedef struct packed {
        logic             operation;
        logic [SYM_W-1:0] symbol;
        logic             last_symbol;
        logic [POS_W-1:0] first_position;
        logic [POS_W-1:0] second_position;
    } req_t;

    typedef struct packed {
        logic [STA_W-1:0] status;
        logic [PLN_W-1:0] prefix_length;
    } rsp_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_INIT_RD, S_INIT_WR,
        S_CLR,
        S_CNT_RD, S_CNT_KEY, S_CNT_WR,
        S_PFX_RD, S_PFX_WR,
        S_PLC_RD, S_PLC_P, S_PLC_K, S_PLC_WR,
        S_CPY_RD, S_CPY_WR,
        S_RN_SA, S_RN_A, S_RN_V, S_RN_S,
        S_LOOP,
        S_SH_FILL, S_SH_RD, S_SH_WR,
        S_KS_RK, S_KS_R, S_KS_J, S_KS_TA, S_KS_TB, S_KS_TC, S_KS_WR,
        S_M0_RD, S_M0_WR,
        S_ML_CHK, S_ML_RA, S_ML_RB, S_ML_WR,
        S_FIN,
        S_Q_RA, S_Q_RB, S_Q_LV, S_Q_XA, S_Q_XB, S_Q_RES,
        S_EMIT
    } state_t;

    // Sparse table address: level row times row pitch plus index
    function automatic logic [MT_AW-1:0] mt_addr(input logic [LV_W-1:0] lv,
                                                 input logic [IDX_W-1:0] idx);
        mt_addr = MT_AW'(lv) * MT_AW'(MAX_LENGTH) + MT_AW'(idx);
    endfunction

endpackage

// ----- src/salq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module salq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- src/suffix_array_lcp_query_core.sv -----
`timescale 1ns / 1ps
// The last load (with the last mark) runs the build: the radix passes, the Kasai heights
//   with their symbol compares, and the sparse table level by level, all paced by the
//   single read port of each memory.
// Queries read the two ranks and two table entries when these are needed.
// One transaction is in work at a time; a finished result waits in the output register.
// Reset clears control state only; the memories need no clearing.
// ----------------------------------------------------------------------------
// suffix_array_lcp_query_core
// Loads a string, builds suffix array, heights and a min sparse table, answers LCP queries.
// ----------------------------------------------------------------------------
module suffix_array_lcp_query_core
    import salq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    state_t state_reg, state_next;

    logic [VAL_W-1:0] len_reg, len_next;
    logic             built_reg, built_next;
    logic [VAL_W-1:0] i_reg, i_next;
    logic [VAL_W-1:0] m_reg, m_next;
    logic [VAL_W-1:0] k_reg, k_next;
    logic [VAL_W-1:0] top_reg, top_next;
    logic [VAL_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0] acc_reg, acc_next;
    logic [VAL_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0] p_reg, p_next;
    logic [IDX_W-1:0] a_reg, a_next;
    logic [VAL_W-1:0] v_reg, v_next;
    logic [VAL_W-1:0] pv_reg, pv_next;
    logic [VAL_W-1:0] ps_reg, ps_next;
    logic             sec_ok_reg, sec_ok_next;
    logic             first_reg, first_next;
    logic [VAL_W-1:0] h_reg, h_next;
    logic [IDX_W-1:0] r_reg, r_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [SYM_W-1:0] ta_reg, ta_next;
    logic [LV_W-1:0]  lv_reg, lv_next;
    logic [VAL_W-1:0] x_reg, x_next;
    logic [IDX_W-1:0] qb_reg, qb_next;
    logic [POS_W-1:0] qp_reg, qp_next;
    logic [POS_W-1:0] qq_reg, qq_next;
    logic [STA_W-1:0] res_st_reg, res_st_next;
    logic [PLN_W-1:0] res_len_reg, res_len_next;
    logic             ov_reg, ov_next;
    rsp_t             rsp_reg, rsp_next;

    // Memory ports
    logic             text_we;
    logic [IDX_W-1:0] text_wa, text_ra;
    logic [SYM_W-1:0] text_wd, text_rd;
    logic             rank_we;
    logic [IDX_W-1:0] rank_wa, rank_ra;
    logic [VAL_W-1:0] rank_wd, rank_rd;
    logic             scr_we;
    logic [IDX_W-1:0] scr_wa, scr_ra;
    logic [VAL_W-1:0] scr_wd, scr_rd;
    logic             bkt_we;
    logic [BKT_AW-1:0] bkt_wa, bkt_ra;
    logic [VAL_W-1:0] bkt_wd, bkt_rd;
    logic             sa_we;
    logic [IDX_W-1:0] sa_wa, sa_ra;
    logic [IDX_W-1:0] sa_wd, sa_rd;
    logic             hgt_we;
    logic [IDX_W-1:0] hgt_wa, hgt_ra;
    logic [VAL_W-1:0] hgt_wd, hgt_rd;
    logic             mt_we;
    logic [MT_AW-1:0] mt_wa, mt_ra;
    logic [VAL_W-1:0] mt_wd, mt_rd;

    // Shared combinational helpers
    logic [VAL_W-1:0] load_pos;
    logic             load_room;
    logic [VAL_W-1:0] rank_key;
    logic [VAL_W-1:0] bkt_key;
    logic [VAL_W:0]   ih_sum, jh_sum, ak_sum;
    logic [VAL_W:0]   pow_lv, half_lv;
    logic [IDX_W-1:0] rank_pos;
    logic             emit_fire;

    assign load_pos  = built_reg ? '0 : len_reg;
    assign load_room = (load_pos < VAL_W'(MAX_LENGTH));
    assign rank_key  = (rank_rd > top_reg) ? top_reg : rank_rd;
    assign bkt_key   = rank_key;
    assign rank_pos  = IDX_W'(rank_rd - VAL_W'(1));
    assign ih_sum    = (VAL_W+1)'(i_reg) + (VAL_W+1)'(h_reg);
    assign jh_sum    = (VAL_W+1)'(j_reg) + (VAL_W+1)'(h_reg);
    assign ak_sum    = (VAL_W+1)'(a_reg) + (VAL_W+1)'(k_reg);
    assign pow_lv    = (VAL_W+1)'(1) << lv_reg;
    assign half_lv   = pow_lv >> 1;
    assign emit_fire = (state_reg == S_EMIT) && (!ov_reg || !rsp_stall);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = ov_reg;
    assign rsp       = rsp_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            built_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            built_reg <= built_next;
            ov_reg    <= ov_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        m_reg       <= m_next;
        k_reg       <= k_next;
        top_reg     <= top_next;
        cnt_reg     <= cnt_next;
        acc_reg     <= acc_next;
        key_reg     <= key_next;
        p_reg       <= p_next;
        a_reg       <= a_next;
        v_reg       <= v_next;
        pv_reg      <= pv_next;
        ps_reg      <= ps_next;
        sec_ok_reg  <= sec_ok_next;
        first_reg   <= first_next;
        h_reg       <= h_next;
        r_reg       <= r_next;
        j_reg       <= j_next;
        ta_reg      <= ta_next;
        lv_reg      <= lv_next;
        x_reg       <= x_next;
        qb_reg      <= qb_next;
        qp_reg      <= qp_next;
        qq_reg      <= qq_next;
        res_st_reg  <= res_st_next;
        res_len_reg <= res_len_next;
        rsp_reg     <= rsp_next;
    end

    // Next state and sequencer registers
    always_comb
    begin
        logic [VAL_W-1:0] sum;
        logic [VAL_W-1:0] sec;
        logic [VAL_W-1:0] cnt_new;
        logic [VAL_W-1:0] knew;
        logic [IDX_W-1:0] ra, rb, lo, hi, span;
        logic [LV_W-1:0]  hb;

        state_next   = state_reg;
        len_next     = len_reg;
        built_next   = built_reg;
        i_next       = i_reg;
        m_next       = m_reg;
        k_next       = k_reg;
        top_next     = top_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        key_next     = key_reg;
        p_next       = p_reg;
        a_next       = a_reg;
        v_next       = v_reg;
        pv_next      = pv_reg;
        ps_next      = ps_reg;
        sec_ok_next  = sec_ok_reg;
        first_next   = first_reg;
        h_next       = h_reg;
        r_next       = r_reg;
        j_next       = j_reg;
        ta_next      = ta_reg;
        lv_next      = lv_reg;
        x_next       = x_reg;
        qb_next      = qb_reg;
        qp_next      = qp_reg;
        qq_next      = qq_reg;
        res_st_next  = res_st_reg;
        res_len_next = res_len_reg;
        sum          = '0;
        sec          = '0;
        cnt_new      = '0;
        knew         = '0;
        ra           = '0;
        rb           = '0;
        lo           = '0;
        hi           = '0;
        span         = '0;
        hb           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.operation == OP_LOAD)
                    begin
                        built_next = 1'b0;
                        len_next   = load_room ? load_pos + VAL_W'(1) : load_pos;
                        if (req.last_symbol)
                        begin
                            i_next     = '0;
                            k_next     = VAL_W'(1);
                            first_next = 1'b1;
                            state_next = S_INIT_RD;
                        end
                    end
                    else
                    begin
                        qp_next = req.first_position;
                        qq_next = req.second_position;
                        if (!built_reg || VAL_W'(req.first_position) >= len_reg
                            || VAL_W'(req.second_position) >= len_reg)
                        begin
                            res_st_next  = ST_RANGE;
                            res_len_next = '0;
                            state_next   = S_EMIT;
                        end
                        else if (req.first_position == req.second_position)
                        begin
                            res_st_next  = ST_ANSWER;
                            res_len_next = PLN_W'(len_reg - VAL_W'(req.first_position));
                            state_next   = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_Q_RA;
                        end
                    end
                end
            end

            // Initial ranks from symbols, identity order
            S_INIT_RD:
            begin
                if (i_reg == len_reg)
                begin
                    i_next     = '0;
                    top_next   = VAL_W'(TOP0);
                    state_next = S_CLR;
                end
                else
                begin
                    state_next = S_INIT_WR;
                end
            end
            S_INIT_WR:
            begin
                i_next     = i_reg + VAL_W'(1);
                state_next = S_INIT_RD;
            end

            // Counting sort: clear, count, prefix, place
            S_CLR:
            begin
                if (i_reg == top_reg)
                begin
                    i_next     = '0;
                    state_next = S_CNT_RD;
                end
                else
                begin
                    i_next = i_reg + VAL_W'(1);
                end
            end
            S_CNT_RD:
            begin
                if (i_reg == len_reg)
                begin
                    i_next     = '0;
                    acc_next   = '0;
                    state_next = S_PFX_RD;
                end
                else
                begin
                    state_next = S_CNT_KEY;
                end
            end
            S_CNT_KEY:
            begin
                key_next   = bkt_key;
                state_next = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                i_next     = i_reg + VAL_W'(1);
                state_next = S_CNT_RD;
            end
            S_PFX_RD:
            begin
                if (i_reg > top_reg)
                begin
                    i_next     = len_reg;
                    state_next = S_PLC_RD;
                end
                else
                begin
                    state_next = S_PFX_WR;
                end
            end
            S_PFX_WR:
            begin
                sum        = acc_reg + bkt_rd;
                acc_next   = sum;
                i_next     = i_reg + VAL_W'(1);
                state_next = S_PFX_RD;
            end
            S_PLC_RD:
            begin
                if (i_reg == '0)
                begin
                    state_next = S_CPY_RD;
                end
                else
                begin
                    state_next = S_PLC_P;
                end
            end
            S_PLC_P:
            begin
                p_next     = scr_rd[IDX_W-1:0];
                state_next = S_PLC_K;
            end
            S_PLC_K:
            begin
                key_next   = bkt_key;
                state_next = S_PLC_WR;
            end
            S_PLC_WR:
            begin
                i_next     = i_reg - VAL_W'(1);
                state_next = S_PLC_RD;
            end

            // Save old ranks
            S_CPY_RD:
            begin
                if (i_reg == len_reg)
                begin
                    i_next     = '0;
                    state_next = S_RN_SA;
                end
                else
                begin
                    state_next = S_CPY_WR;
                end
            end
            S_CPY_WR:
            begin
                i_next     = i_reg + VAL_W'(1);
                state_next = S_CPY_RD;
            end

            // Dense renumbering over the sorted order
            S_RN_SA:
            begin
                if (i_reg == len_reg)
                begin
                    state_next = S_LOOP;
                end
                else
                begin
                    state_next = S_RN_A;
                end
            end
            S_RN_A:
            begin
                a_next     = sa_rd;
                state_next = S_RN_V;
            end
            S_RN_V:
            begin
                v_next      = scr_rd;
                sec_ok_next = !first_reg && (ak_sum < (VAL_W+1)'(len_reg));
                state_next  = S_RN_S;
            end
            S_RN_S:
            begin
                sec = sec_ok_reg ? scr_rd : '0;
                if (i_reg == '0)
                begin
                    cnt_new = VAL_W'(1);
                end
                else if (v_reg != pv_reg || sec != ps_reg)
                begin
                    cnt_new = cnt_reg + VAL_W'(1);
                end
                else
                begin
                    cnt_new = cnt_reg;
                end
                cnt_next   = cnt_new;
                pv_next    = v_reg;
                ps_next    = sec;
                i_next     = i_reg + VAL_W'(1);
                state_next = S_RN_SA;
            end

            // Doubling loop control
            S_LOOP:
            begin
                knew       = first_reg ? k_reg : VAL_W'(k_reg << 1);
                first_next = 1'b0;
                k_next     = knew;
                if (cnt_reg < len_reg && knew < len_reg)
                begin
                    i_next     = len_reg - knew;
                    m_next     = '0;
                    state_next = S_SH_FILL;
                end
                else
                begin
                    i_next     = '0;
                    h_next     = '0;
                    state_next = S_KS_RK;
                end
            end

            // Order by second key
            S_SH_FILL:
            begin
                if (i_reg == len_reg)
                begin
                    i_next     = '0;
                    state_next = S_SH_RD;
                end
                else
                begin
                    i_next = i_reg + VAL_W'(1);
                    m_next = m_reg + VAL_W'(1);
                end
            end
            S_SH_RD:
            begin
                if (i_reg == len_reg)
                begin
                    i_next     = '0;
                    top_next   = cnt_reg;
                    state_next = S_CLR;
                end
                else
                begin
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                if (VAL_W'(sa_rd) >= k_reg)
                begin
                    m_next = m_reg + VAL_W'(1);
                end
                i_next     = i_reg + VAL_W'(1);
                state_next = S_SH_RD;
            end

            // Kasai heights
            S_KS_RK:
            begin
                if (i_reg == len_reg)
                begin
                    i_next     = '0;
                    state_next = S_M0_RD;
                end
                else
                begin
                    state_next = S_KS_R;
                end
            end
            S_KS_R:
            begin
                r_next = rank_pos;
                if (rank_pos == '0)
                begin
                    h_next     = '0;
                    i_next     = i_reg + VAL_W'(1);
                    state_next = S_KS_RK;
                end
                else
                begin
                    state_next = S_KS_J;
                end
            end
            S_KS_J:
            begin
                j_next     = sa_rd;
                state_next = S_KS_TA;
            end
            S_KS_TA:
            begin
                if (ih_sum < (VAL_W+1)'(len_reg) && jh_sum < (VAL_W+1)'(len_reg))
                begin
                    state_next = S_KS_TB;
                end
                else
                begin
                    state_next = S_KS_WR;
                end
            end
            S_KS_TB:
            begin
                ta_next    = text_rd;
                state_next = S_KS_TC;
            end
            S_KS_TC:
            begin
                if (text_rd == ta_reg)
                begin
                    h_next     = h_reg + VAL_W'(1);
                    state_next = S_KS_TA;
                end
                else
                begin
                    state_next = S_KS_WR;
                end
            end
            S_KS_WR:
            begin
                h_next     = (h_reg != '0) ? h_reg - VAL_W'(1) : '0;
                i_next     = i_reg + VAL_W'(1);
                state_next = S_KS_RK;
            end

            // Sparse table level zero
            S_M0_RD:
            begin
                if (i_reg == len_reg)
                begin
                    lv_next    = LV_W'(1);
                    state_next = S_ML_CHK;
                end
                else
                begin
                    state_next = S_M0_WR;
                end
            end
            S_M0_WR:
            begin
                i_next     = i_reg + VAL_W'(1);
                state_next = S_M0_RD;
            end

            // Higher levels
            S_ML_CHK:
            begin
                if (lv_reg < LV_W'(TABLE_LEVELS) && pow_lv <= (VAL_W+1)'(len_reg))
                begin
                    i_next     = '0;
                    state_next = S_ML_RA;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_ML_RA:
            begin
                if ((VAL_W+1)'(i_reg) + pow_lv > (VAL_W+1)'(len_reg))
                begin
                    lv_next    = lv_reg + LV_W'(1);
                    state_next = S_ML_CHK;
                end
                else
                begin
                    state_next = S_ML_RB;
                end
            end
            S_ML_RB:
            begin
                x_next     = mt_rd;
                state_next = S_ML_WR;
            end
            S_ML_WR:
            begin
                i_next     = i_reg + VAL_W'(1);
                state_next = S_ML_RA;
            end

            S_FIN:
            begin
                built_next   = 1'b1;
                res_st_next  = ST_DONE;
                res_len_next = '0;
                state_next   = S_EMIT;
            end

            // Range minimum query
            S_Q_RA:
            begin
                state_next = S_Q_RB;
            end
            S_Q_RB:
            begin
                p_next     = rank_pos;
                state_next = S_Q_LV;
            end
            S_Q_LV:
            begin
                ra = p_reg;
                rb = rank_pos;
                lo = (ra < rb) ? ra : rb;
                hi = (ra < rb) ? rb : ra;
                span = hi - lo;
                for (int b = 0; b < IDX_W; b++)
                begin
                    if (span[b])
                    begin
                        hb = LV_W'(b);
                    end
                end
                if (hb > LV_W'(TABLE_LEVELS - 1))
                begin
                    hb = LV_W'(TABLE_LEVELS - 1);
                end
                a_next     = lo + IDX_W'(1);
                qb_next    = hi;
                lv_next    = hb;
                state_next = S_Q_XA;
            end
            S_Q_XA:
            begin
                state_next = S_Q_XB;
            end
            S_Q_XB:
            begin
                x_next     = mt_rd;
                state_next = S_Q_RES;
            end
            S_Q_RES:
            begin
                res_st_next  = ST_ANSWER;
                res_len_next = PLN_W'((x_reg < mt_rd) ? x_reg : mt_rd);
                state_next   = S_EMIT;
            end

            S_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory port control
    always_comb
    begin
        logic [VAL_W-1:0] dec;
        logic [VAL_W:0]   qidx;

        text_we = 1'b0; text_wa = '0; text_wd = '0; text_ra = '0;
        rank_we = 1'b0; rank_wa = '0; rank_wd = '0; rank_ra = '0;
        scr_we  = 1'b0; scr_wa  = '0; scr_wd  = '0; scr_ra  = '0;
        bkt_we  = 1'b0; bkt_wa  = '0; bkt_wd  = '0; bkt_ra  = '0;
        sa_we   = 1'b0; sa_wa   = '0; sa_wd   = '0; sa_ra   = '0;
        hgt_we  = 1'b0; hgt_wa  = '0; hgt_wd  = '0; hgt_ra  = '0;
        mt_we   = 1'b0; mt_wa   = '0; mt_wd   = '0; mt_ra   = '0;
        dec     = '0;
        qidx    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req.operation == OP_LOAD && load_room)
                begin
                    text_we = 1'b1;
                    text_wa = load_pos[IDX_W-1:0];
                    text_wd = req.symbol;
                end
            end
            S_INIT_RD:
            begin
                text_ra = i_reg[IDX_W-1:0];
            end
            S_INIT_WR:
            begin
                rank_we = 1'b1;
                rank_wa = i_reg[IDX_W-1:0];
                rank_wd = VAL_W'(text_rd) + VAL_W'(1);
                scr_we  = 1'b1;
                scr_wa  = i_reg[IDX_W-1:0];
                scr_wd  = i_reg;
            end
            S_CLR:
            begin
                bkt_we = 1'b1;
                bkt_wa = i_reg[BKT_AW-1:0];
                bkt_wd = '0;
            end
            S_CNT_RD:
            begin
                rank_ra = i_reg[IDX_W-1:0];
            end
            S_CNT_KEY:
            begin
                bkt_ra = bkt_key[BKT_AW-1:0];
            end
            S_CNT_WR:
            begin
                bkt_we = 1'b1;
                bkt_wa = key_reg[BKT_AW-1:0];
                bkt_wd = bkt_rd + VAL_W'(1);
            end
            S_PFX_RD:
            begin
                bkt_ra = i_reg[BKT_AW-1:0];
            end
            S_PFX_WR:
            begin
                bkt_we = 1'b1;
                bkt_wa = i_reg[BKT_AW-1:0];
                bkt_wd = acc_reg + bkt_rd;
            end
            S_PLC_RD:
            begin
                scr_ra = IDX_W'(i_reg - VAL_W'(1));
            end
            S_PLC_P:
            begin
                rank_ra = scr_rd[IDX_W-1:0];
            end
            S_PLC_K:
            begin
                bkt_ra = bkt_key[BKT_AW-1:0];
            end
            S_PLC_WR:
            begin
                dec    = bkt_rd - VAL_W'(1);
                bkt_we = 1'b1;
                bkt_wa = key_reg[BKT_AW-1:0];
                bkt_wd = dec;
                sa_we  = 1'b1;
                sa_wa  = dec[IDX_W-1:0];
                sa_wd  = p_reg;
            end
            S_CPY_RD:
            begin
                rank_ra = i_reg[IDX_W-1:0];
            end
            S_CPY_WR:
            begin
                scr_we = 1'b1;
                scr_wa = i_reg[IDX_W-1:0];
                scr_wd = rank_rd;
            end
            S_RN_SA:
            begin
                sa_ra = i_reg[IDX_W-1:0];
            end
            S_RN_A:
            begin
                scr_ra = sa_rd;
            end
            S_RN_V:
            begin
                scr_ra = ak_sum[IDX_W-1:0];
            end
            S_RN_S:
            begin
                rank_we = 1'b1;
                rank_wa = a_reg;
                rank_wd = cnt_next;
            end
            S_SH_FILL:
            begin
                if (i_reg != len_reg)
                begin
                    scr_we = 1'b1;
                    scr_wa = m_reg[IDX_W-1:0];
                    scr_wd = i_reg;
                end
            end
            S_SH_RD:
            begin
                sa_ra = i_reg[IDX_W-1:0];
            end
            S_SH_WR:
            begin
                if (VAL_W'(sa_rd) >= k_reg)
                begin
                    scr_we = 1'b1;
                    scr_wa = m_reg[IDX_W-1:0];
                    scr_wd = VAL_W'(sa_rd) - k_reg;
                end
            end
            S_KS_RK:
            begin
                rank_ra = i_reg[IDX_W-1:0];
            end
            S_KS_R:
            begin
                if (rank_pos == '0)
                begin
                    hgt_we = 1'b1;
                    hgt_wa = '0;
                    hgt_wd = '0;
                end
                else
                begin
                    sa_ra = rank_pos - IDX_W'(1);
                end
            end
            S_KS_TA:
            begin
                text_ra = ih_sum[IDX_W-1:0];
            end
            S_KS_TB:
            begin
                text_ra = jh_sum[IDX_W-1:0];
            end
            S_KS_WR:
            begin
                hgt_we = 1'b1;
                hgt_wa = r_reg;
                hgt_wd = h_reg;
            end
            S_M0_RD:
            begin
                hgt_ra = i_reg[IDX_W-1:0];
            end
            S_M0_WR:
            begin
                mt_we = 1'b1;
                mt_wa = mt_addr('0, i_reg[IDX_W-1:0]);
                mt_wd = hgt_rd;
            end
            S_ML_RA:
            begin
                mt_ra = mt_addr(lv_reg - LV_W'(1), i_reg[IDX_W-1:0]);
            end
            S_ML_RB:
            begin
                mt_ra = mt_addr(lv_reg - LV_W'(1),
                                IDX_W'((VAL_W+1)'(i_reg) + half_lv));
            end
            S_ML_WR:
            begin
                mt_we = 1'b1;
                mt_wa = mt_addr(lv_reg, i_reg[IDX_W-1:0]);
                mt_wd = (x_reg < mt_rd) ? x_reg : mt_rd;
            end
            S_Q_RA:
            begin
                rank_ra = IDX_W'(qp_reg);
            end
            S_Q_RB:
            begin
                rank_ra = IDX_W'(qq_reg);
            end
            S_Q_XA:
            begin
                mt_ra = mt_addr(lv_reg, a_reg);
            end
            S_Q_XB:
            begin
                qidx  = (VAL_W+1)'(qb_reg) + (VAL_W+1)'(1) - pow_lv;
                mt_ra = mt_addr(lv_reg, qidx[IDX_W-1:0]);
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_comb
    begin
        ov_next  = ov_reg && rsp_stall;
        rsp_next = rsp_reg;
        if (emit_fire)
        begin
            ov_next                = 1'b1;
            rsp_next.status        = res_st_reg;
            rsp_next.prefix_length = res_len_reg;
        end
    end

    // Storage
    salq_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LENGTH)) u_text_ram (
        .clk(clk), .we(text_we), .waddr(text_wa), .wdata(text_wd),
        .raddr(text_ra), .rdata(text_rd)
    );
    salq_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LENGTH)) u_rank_ram (
        .clk(clk), .we(rank_we), .waddr(rank_wa), .wdata(rank_wd),
        .raddr(rank_ra), .rdata(rank_rd)
    );
    salq_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LENGTH)) u_scr_ram (
        .clk(clk), .we(scr_we), .waddr(scr_wa), .wdata(scr_wd),
        .raddr(scr_ra), .rdata(scr_rd)
    );
    salq_ram #(.WIDTH(VAL_W), .DEPTH(BKT_DEPTH)) u_bkt_ram (
        .clk(clk), .we(bkt_we), .waddr(bkt_wa), .wdata(bkt_wd),
        .raddr(bkt_ra), .rdata(bkt_rd)
    );
    salq_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LENGTH)) u_sa_ram (
        .clk(clk), .we(sa_we), .waddr(sa_wa), .wdata(sa_wd),
        .raddr(sa_ra), .rdata(sa_rd)
    );
    salq_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LENGTH)) u_hgt_ram (
        .clk(clk), .we(hgt_we), .waddr(hgt_wa), .wdata(hgt_wd),
        .raddr(hgt_ra), .rdata(hgt_rd)
    );
    salq_ram #(.WIDTH(VAL_W), .DEPTH(MT_DEPTH)) u_mt_ram (
        .clk(clk), .we(mt_we), .waddr(mt_wa), .wdata(mt_wd),
        .raddr(mt_ra), .rdata(mt_rd)
    );

endmodule
